### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the bit manipulation unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge once reset is released
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/bmu_pkg.sv
// Package with operation codes and field widths of the bit manipulation unit
package bmu_pkg;

    localparam int unsigned KindWidth     = 5;
    localparam int unsigned OperandWidth  = 64;
    localparam int unsigned DistanceWidth = 8;

    typedef enum logic [KindWidth-1:0] {
        KIND_POPCNT  = 5'd0,
        KIND_LOWBIT  = 5'd1,
        KIND_HIGHBIT = 5'd2,
        KIND_BSWAP16 = 5'd3,
        KIND_BSWAP32 = 5'd4,
        KIND_BSWAP64 = 5'd5,
        KIND_RROT8   = 5'd6,
        KIND_RROT16  = 5'd7,
        KIND_RROT32  = 5'd8,
        KIND_RROT64  = 5'd9,
        KIND_LROT8   = 5'd10,
        KIND_LROT16  = 5'd11,
        KIND_LROT32  = 5'd12,
        KIND_LROT64  = 5'd13,
        KIND_SHL32   = 5'd14,
        KIND_SHL64   = 5'd15,
        KIND_SHR32   = 5'd16,
        KIND_SHR64   = 5'd17,
        KIND_SAR32   = 5'd18,
        KIND_SAR64   = 5'd19
    } kind_t;

    typedef logic [KindWidth-1:0]     kind_bits_t;
    typedef logic [OperandWidth-1:0]  word_t;
    typedef logic [DistanceWidth-1:0] dist_t;

endpackage

### rtl/core/bmu_ops.sv
// Combinational datapath: bit counts, byte swaps, rotates and shifts
module bmu_ops
(
    input  bmu_pkg::kind_bits_t kind,
    input  bmu_pkg::word_t      operand,
    input  bmu_pkg::dist_t      distance,
    output bmu_pkg::word_t      result
);

    // OR together the indexes of set bits; exact for a one-hot word
    function automatic logic [5:0] enc64(input logic [63:0] onehot);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | 6'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] r);
        logic [15:0] t;
        t = {v, v} << r;
        return t[15:8];
    endfunction

    function automatic logic [15:0] rotl16(input logic [15:0] v, input logic [3:0] r);
        logic [31:0] t;
        t = {v, v} << r;
        return t[31:16];
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] t;
        t = {v, v} << r;
        return t[63:32];
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
        logic [127:0] t;
        t = {v, v} << r;
        return t[127:64];
    endfunction

    // Logical shift: left for a >= 0, right for a < 0, empty at width or more
    function automatic logic [31:0] lsh32(input logic [31:0] v, input logic signed [8:0] a);
        logic [8:0] mag;
        logic [31:0] r;
        mag = a[8] ? 9'(-a) : 9'(a);
        if (mag >= 9'd32)
        begin
            r = 32'd0;
        end
        else if (a[8])
        begin
            r = v >> mag[4:0];
        end
        else
        begin
            r = v << mag[4:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] lsh64(input logic [63:0] v, input logic signed [8:0] a);
        logic [8:0] mag;
        logic [63:0] r;
        mag = a[8] ? 9'(-a) : 9'(a);
        if (mag >= 9'd64)
        begin
            r = 64'd0;
        end
        else if (a[8])
        begin
            r = v >> mag[5:0];
        end
        else
        begin
            r = v << mag[5:0];
        end
        return r;
    endfunction

    // Arithmetic right shift; a negative distance shifts left instead
    function automatic logic [31:0] sar32(input logic [31:0] v, input logic signed [8:0] a);
        logic [31:0] r;
        if (a[8])
        begin
            r = lsh32(v, 9'(-a));
        end
        else if (a >= 9'sd32)
        begin
            r = {32{v[31]}};
        end
        else
        begin
            r = 32'($signed(v) >>> a[4:0]);
        end
        return r;
    endfunction

    function automatic logic [63:0] sar64(input logic [63:0] v, input logic signed [8:0] a);
        logic [63:0] r;
        if (a[8])
        begin
            r = lsh64(v, 9'(-a));
        end
        else if (a >= 9'sd64)
        begin
            r = {64{v[63]}};
        end
        else
        begin
            r = 64'($signed(v) >>> a[5:0]);
        end
        return r;
    endfunction

    logic [63:0]       abs_val;
    logic [63:0]       low_iso;
    logic [63:0]       abs_rev;
    logic [63:0]       high_iso;
    logic [6:0]        pop_cnt;
    logic [6:0]        low_pos;
    logic [6:0]        high_pos;
    logic [63:0]       bswap64;
    logic signed [8:0] dist_s;
    logic signed [8:0] dist_neg;
    logic [7:0]        dist_rr;

    always_comb
    begin
        abs_val = operand[63] ? (~operand + 64'd1) : operand;
        pop_cnt = 7'($countones(abs_val));

        // Isolate the lowest set bit, then encode its index
        low_iso = operand & (~operand + 64'd1);
        low_pos = (operand == 64'd0) ? 7'd0 : ({1'b0, enc64(low_iso)} + 7'd1);

        // Reverse so the top set bit becomes the lowest one
        for (int i = 0; i < 64; i++)
        begin
            abs_rev[i] = abs_val[63 - i];
        end
        high_iso = abs_rev & (~abs_rev + 64'd1);
        high_pos = (abs_val == 64'd0) ? 7'd0 : (7'd64 - {1'b0, enc64(high_iso)});

        for (int i = 0; i < 8; i++)
        begin
            bswap64[8*i +: 8] = operand[8*(7 - i) +: 8];
        end

        dist_s   = {distance[7], distance};
        dist_neg = -dist_s;
        // Right rotate by r is left rotate by (width - r) mod width
        dist_rr  = ~distance + 8'd1;
    end

    always_comb
    begin
        case (kind)
            bmu_pkg::KIND_POPCNT:  result = {57'd0, pop_cnt};
            bmu_pkg::KIND_LOWBIT:  result = {57'd0, low_pos};
            bmu_pkg::KIND_HIGHBIT: result = {57'd0, high_pos};
            bmu_pkg::KIND_BSWAP16: result = {operand[63:16], operand[7:0], operand[15:8]};
            bmu_pkg::KIND_BSWAP32: result = {operand[63:32], operand[7:0], operand[15:8],
                                             operand[23:16], operand[31:24]};
            bmu_pkg::KIND_BSWAP64: result = bswap64;
            bmu_pkg::KIND_RROT8:   result = {operand[63:8],  rotl8(operand[7:0], dist_rr[2:0])};
            bmu_pkg::KIND_RROT16:  result = {operand[63:16], rotl16(operand[15:0], dist_rr[3:0])};
            bmu_pkg::KIND_RROT32:  result = {operand[63:32], rotl32(operand[31:0], dist_rr[4:0])};
            bmu_pkg::KIND_RROT64:  result = rotl64(operand, dist_rr[5:0]);
            bmu_pkg::KIND_LROT8:   result = {operand[63:8],  rotl8(operand[7:0], distance[2:0])};
            bmu_pkg::KIND_LROT16:  result = {operand[63:16], rotl16(operand[15:0], distance[3:0])};
            bmu_pkg::KIND_LROT32:  result = {operand[63:32], rotl32(operand[31:0], distance[4:0])};
            bmu_pkg::KIND_LROT64:  result = rotl64(operand, distance[5:0]);
            bmu_pkg::KIND_SHL32:   result = {operand[63:32], lsh32(operand[31:0], dist_s)};
            bmu_pkg::KIND_SHL64:   result = lsh64(operand, dist_s);
            bmu_pkg::KIND_SHR32:   result = {operand[63:32], lsh32(operand[31:0], dist_neg)};
            bmu_pkg::KIND_SHR64:   result = lsh64(operand, dist_neg);
            bmu_pkg::KIND_SAR32:   result = {operand[63:32], sar32(operand[31:0], dist_s)};
            bmu_pkg::KIND_SAR64:   result = sar64(operand, dist_s);
            default:               result = 64'd0;
        endcase
    end

endmodule

### rtl/core/bit_manipulation_unit.sv
// Top level of the bit manipulation unit: input register, datapath, result register
// An input beat lands in the input register; its result then lands in the result register and raises out_valid.
// Throughput: one beat per cycle; the pipeline stalls only when out_ready is low.
// A stalled result holds while one more beat waits in the input register.
// Reset: rst_n clears both stage valid flags asynchronously; payload is not reset.
`include "assert_macros.svh"

module bit_manipulation_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bmu_pkg::kind_bits_t kind,
    input  bmu_pkg::word_t      operand,
    input  bmu_pkg::dist_t      distance,
    output logic                out_valid,
    input  logic                out_ready,
    output bmu_pkg::word_t      result
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    bmu_pkg::kind_bits_t kind_reg;
    bmu_pkg::word_t      operand_reg;
    bmu_pkg::dist_t      distance_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    bmu_pkg::word_t      result_reg;
    bmu_pkg::word_t      result_next;
    logic                s1_adv;
    logic                in_beat;

    // Stage 1 moves on when the result register is empty or being drained
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_beat  = in_valid && in_ready;

    bmu_ops u_ops
    (
        .kind     (kind_reg),
        .operand  (operand_reg),
        .distance (distance_reg),
        .result   (result_next)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            kind_reg     <= kind;
            operand_reg  <= operand;
            distance_reg <= distance;
        end
        if (s1_adv && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    `ASSERT_ALWAYS(a_full_blocks_input, !(s1_valid_reg && !s1_adv && in_ready), "input taken while pipeline full")
    `ASSERT_NEXT(a_beat_loads_s1, in_beat, s1_valid_reg, "accepted beat lost in stage 1")
    `ASSERT_NEXT(a_s1_moves_to_out, s1_adv && s1_valid_reg, out_valid_reg, "stage 1 beat lost on advance")
    `ASSERT_NEXT(a_empty_stays_empty, !s1_valid_reg && !in_beat && out_ready, !out_valid_reg, "result appeared from empty pipeline")

endmodule

### verif/bit_manipulation_unit_test.sv
// Self-checking testbench of the bit manipulation unit with randomized traffic
`timescale 1ns / 1ps

module bit_manipulation_unit_test;

    localparam bmu_pkg::kind_bits_t FirstUnusedKind = 5'd20;
    localparam bmu_pkg::kind_bits_t LastUnusedKind  = 5'd31;
    localparam int unsigned PhaseCount     = 5;
    localparam int unsigned BeatsPerPhase  = 100;
    localparam int unsigned WatchdogLimit  = 2000;
    localparam int unsigned DrainCycles    = 8;

    class bmu_scoreboard;
        bmu_pkg::word_t expected_q[$];
        int unsigned    beats_noted;
        int unsigned    results_checked;
        int unsigned    errors;
        bit             kind_seen[32];

        function bmu_pkg::word_t field_mask(int w);
            return (w >= 64) ? '1 : ((bmu_pkg::word_t'(1) << w) - bmu_pkg::word_t'(1));
        endfunction

        function bmu_pkg::word_t swap_low_bytes(bmu_pkg::word_t x, int nbytes);
            bmu_pkg::word_t m;
            bmu_pkg::word_t sw;
            m  = field_mask(nbytes * 8);
            sw = '0;
            for (int i = 0; i < nbytes; i++)
                sw[8*(nbytes-1-i) +: 8] = x[8*i +: 8];
            return (x & ~m) | (sw & m);
        endfunction

        // rotate the low w bits left by r, r already in 0..w-1
        function bmu_pkg::word_t rotate_low(bmu_pkg::word_t x, int w, int r);
            bmu_pkg::word_t m;
            bmu_pkg::word_t lo;
            bmu_pkg::word_t rot;
            m  = field_mask(w);
            lo = x & m;
            if (r == 0)
                rot = lo;
            else
                rot = ((lo << r) | (lo >> (w - r))) & m;
            return (x & ~m) | rot;
        endfunction

        // logical shift of the low w bits left by d, right when d is negative
        function bmu_pkg::word_t shift_logical(bmu_pkg::word_t x, int w, int d);
            bmu_pkg::word_t m;
            bmu_pkg::word_t lo;
            bmu_pkg::word_t v;
            m  = field_mask(w);
            lo = x & m;
            if (d >= w || d <= -w)
                v = '0;
            else if (d < 0)
                v = lo >> (-d);
            else
                v = (lo << d) & m;
            return (x & ~m) | v;
        endfunction

        // arithmetic shift of the low w bits right by d, left when d is negative
        function bmu_pkg::word_t shift_arith(bmu_pkg::word_t x, int w, int d);
            bmu_pkg::word_t m;
            bmu_pkg::word_t lo;
            bmu_pkg::word_t v;
            bit             neg;
            m   = field_mask(w);
            lo  = x & m;
            neg = lo[w-1];
            if (d < 0)
                return shift_logical(x, w, -d);
            if (d >= w)
            begin
                v = neg ? m : '0;
            end
            else
            begin
                v = lo >> d;
                if (neg)
                    v |= m & ~(m >> d);
            end
            return (x & ~m) | v;
        endfunction

        function bmu_pkg::word_t predict_result(bmu_pkg::kind_bits_t k, bmu_pkg::word_t x,
                                                bmu_pkg::dist_t d);
            bmu_pkg::word_t ax;
            bmu_pkg::word_t r;
            int             sd;
            int             ud;
            ax = x[63] ? (bmu_pkg::word_t'(0) - x) : x;
            sd = int'($signed(d));
            ud = int'(d);
            r  = '0;
            case (bmu_pkg::kind_t'(k))
                bmu_pkg::KIND_POPCNT:  r = bmu_pkg::word_t'($countones(ax));
                bmu_pkg::KIND_LOWBIT:
                begin
                    for (int i = 63; i >= 0; i--)
                        if (x[i])
                            r = bmu_pkg::word_t'(i + 1);
                end
                bmu_pkg::KIND_HIGHBIT:
                begin
                    for (int i = 0; i < 64; i++)
                        if (ax[i])
                            r = bmu_pkg::word_t'(i + 1);
                end
                bmu_pkg::KIND_BSWAP16: r = swap_low_bytes(x, 2);
                bmu_pkg::KIND_BSWAP32: r = swap_low_bytes(x, 4);
                bmu_pkg::KIND_BSWAP64: r = swap_low_bytes(x, 8);
                // right rotate is a left rotate by the complement of the distance
                bmu_pkg::KIND_RROT8:   r = rotate_low(x, 8, (8 - (ud & 'h7)) & 'h7);
                bmu_pkg::KIND_RROT16:  r = rotate_low(x, 16, (16 - (ud & 'hF)) & 'hF);
                bmu_pkg::KIND_RROT32:  r = rotate_low(x, 32, (32 - (ud & 'h1F)) & 'h1F);
                bmu_pkg::KIND_RROT64:  r = rotate_low(x, 64, (64 - (ud & 'h3F)) & 'h3F);
                bmu_pkg::KIND_LROT8:   r = rotate_low(x, 8, ud & 'h7);
                bmu_pkg::KIND_LROT16:  r = rotate_low(x, 16, ud & 'hF);
                bmu_pkg::KIND_LROT32:  r = rotate_low(x, 32, ud & 'h1F);
                bmu_pkg::KIND_LROT64:  r = rotate_low(x, 64, ud & 'h3F);
                bmu_pkg::KIND_SHL32:   r = shift_logical(x, 32, sd);
                bmu_pkg::KIND_SHL64:   r = shift_logical(x, 64, sd);
                bmu_pkg::KIND_SHR32:   r = shift_logical(x, 32, -sd);
                bmu_pkg::KIND_SHR64:   r = shift_logical(x, 64, -sd);
                bmu_pkg::KIND_SAR32:   r = shift_arith(x, 32, sd);
                bmu_pkg::KIND_SAR64:   r = shift_arith(x, 64, sd);
                default:               r = '0;
            endcase
            return r;
        endfunction

        function void note_beat(bmu_pkg::kind_bits_t k, bmu_pkg::word_t x, bmu_pkg::dist_t d);
            expected_q.push_back(predict_result(k, x, d));
            kind_seen[k] = 1'b1;
            beats_noted++;
        endfunction

        function void check_result(bmu_pkg::word_t actual);
            bmu_pkg::word_t want;
            if (expected_q.size() == 0)
            begin
                $error("result: expected nothing, actual %h", actual);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (actual !== want)
            begin
                $error("result: expected %h, actual %h", want, actual);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function int unsigned kinds_covered();
            int unsigned n;
            n = 0;
            foreach (kind_seen[i])
                n += kind_seen[i];
            return n;
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    bmu_pkg::kind_bits_t kind;
    bmu_pkg::word_t      operand;
    bmu_pkg::dist_t      distance;
    logic                out_valid;
    logic                out_ready;
    bmu_pkg::word_t      result;

    bmu_scoreboard sb;
    bit            quiet;
    int unsigned   stall_left;
    int unsigned   idle_cycles;

    bit_manipulation_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .operand   (operand),
        .distance  (distance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one, none in quiet phases
    function automatic int unsigned pick_idle();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic bmu_pkg::word_t random_operand();
        int unsigned pos;
        pos = $urandom_range(0, 63);
        case ($urandom_range(0, 5))
            0, 1:    return {$urandom, $urandom};
            2:       return bmu_pkg::word_t'(1) << pos;
            3:       return bmu_pkg::word_t'(0) - (bmu_pkg::word_t'(1) << pos);
            4:       return bmu_pkg::word_t'(longint'($urandom_range(0, 16)) - 64'sd8);
            default: return {{32{1'($urandom_range(0, 1))}}, $urandom};
        endcase
    endfunction

    function automatic bmu_pkg::dist_t random_distance();
        int val;
        case ($urandom_range(0, 2))
            0:
                return bmu_pkg::dist_t'($urandom_range(0, 255));
            1:
            begin
                // land near a field width on either side of zero
                val = (8 << $urandom_range(0, 3)) + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1)
                    val = -val;
                return bmu_pkg::dist_t'(val);
            end
            default:
                return bmu_pkg::dist_t'(int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    task automatic send_beat(bmu_pkg::kind_bits_t k, bmu_pkg::word_t x, bmu_pkg::dist_t d);
        int unsigned gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        operand  <= x;
        distance <= d;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(k, x, d);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // sink side: check each result beat, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(result);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left = pick_idle();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WatchdogLimit)
                begin
                    $display("FAIL bit_manipulation_unit");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = '0;
        operand     = '0;
        distance    = '0;
        out_ready   = 1'b0;
        quiet       = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // corner cases: most negative operand, zero, signed distances at the field widths, an unused code
        send_beat(bmu_pkg::KIND_POPCNT,  64'h8000_0000_0000_0000, 8'd0);
        send_beat(bmu_pkg::KIND_POPCNT,  64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
        send_beat(bmu_pkg::KIND_LOWBIT,  64'h0,                   8'd0);
        send_beat(bmu_pkg::KIND_LOWBIT,  64'h8000_0000_0000_0000, 8'd0);
        send_beat(bmu_pkg::KIND_HIGHBIT, 64'h8000_0000_0000_0000, 8'd0);
        send_beat(bmu_pkg::KIND_HIGHBIT, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0);
        send_beat(bmu_pkg::KIND_BSWAP16, 64'h0123_4567_89AB_CDEF, 8'd0);
        send_beat(bmu_pkg::KIND_BSWAP32, 64'h0123_4567_89AB_CDEF, 8'd0);
        send_beat(bmu_pkg::KIND_BSWAP64, 64'h0123_4567_89AB_CDEF, 8'd0);
        send_beat(bmu_pkg::KIND_RROT8,   64'h0123_4567_89AB_CDEF, 8'hFF);
        send_beat(bmu_pkg::KIND_RROT16,  64'h0123_4567_89AB_CDEF, 8'h7F);
        send_beat(bmu_pkg::KIND_RROT32,  64'h0123_4567_89AB_CDEF, 8'h80);
        send_beat(bmu_pkg::KIND_RROT64,  64'h0123_4567_89AB_CDEF, 8'd1);
        send_beat(bmu_pkg::KIND_LROT8,   64'hFEDC_BA98_7654_3210, 8'hFD);
        send_beat(bmu_pkg::KIND_LROT16,  64'hFEDC_BA98_7654_3210, 8'd16);
        send_beat(bmu_pkg::KIND_LROT32,  64'hFEDC_BA98_7654_3210, 8'd31);
        send_beat(bmu_pkg::KIND_LROT64,  64'hFEDC_BA98_7654_3210, 8'h80);
        send_beat(bmu_pkg::KIND_SHL32,   64'hFFFF_FFFF_FFFF_FFFF, 8'd32);
        send_beat(bmu_pkg::KIND_SHL64,   64'hFFFF_FFFF_FFFF_FFFF, 8'hC1);
        send_beat(bmu_pkg::KIND_SHR32,   64'hFFFF_FFFF_FFFF_FFFF, 8'hE1);
        send_beat(bmu_pkg::KIND_SHR64,   64'hFFFF_FFFF_FFFF_FFFF, 8'd64);
        send_beat(bmu_pkg::KIND_SAR32,   64'h0000_0000_8000_0001, 8'd40);
        send_beat(bmu_pkg::KIND_SAR64,   64'h8000_0000_0000_0000, 8'd63);
        send_beat(bmu_pkg::KIND_SAR64,   64'h8000_0000_0000_0001, 8'hFB);
        send_beat(bmu_pkg::KIND_SAR32,   64'hFFFF_FFFF_FFFF_FFFF, 8'hE0);
        send_beat(LastUnusedKind, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        wait_for_results();

        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            // one phase runs at full rate on both sides
            quiet = (phase == 2);
            for (int i = 0; i < BeatsPerPhase; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(bmu_pkg::kind_bits_t'($urandom_range(FirstUnusedKind,
                                                                   LastUnusedKind)),
                              random_operand(), random_distance());
                else
                    send_beat(bmu_pkg::kind_bits_t'($urandom_range(bmu_pkg::KIND_POPCNT,
                                                                   bmu_pkg::KIND_SAR64)),
                              random_operand(), random_distance());
            end
            wait_for_results();
        end
        quiet = 1'b0;

        repeat (DrainCycles) @(posedge clk);
        $display("Sent %0d beats covering %0d of 32 operation codes, including unused ones;",
                 sb.beats_noted, sb.kinds_covered());
        $display("checked %0d results under random source gaps and sink stalls.",
                 sb.results_checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS bit_manipulation_unit");
        else
            $display("FAIL bit_manipulation_unit");
        $finish;
    end

endmodule
